// ----- design/lbs_pkg.sv -----
// Shared types and constants for the lane batch stager.
package lbs_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_STAGED    = 4'd0,
        ST_FULL      = 4'd1,
        ST_LANE_ERR  = 4'd2,
        ST_ID_ERR    = 4'd3,
        ST_NOT_READY = 4'd4,
        ST_FORWARD   = 4'd5,
        ST_NOTHING   = 4'd6,
        ST_STALL     = 4'd7,
        ST_ENTRY     = 4'd8
    } status_t;

    // Input operation codes
    typedef enum logic {
        OP_ACCEPT = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    // Ingress mode register codes
    typedef enum logic {
        MODE_SERIAL = 1'b0,
        MODE_BATCH  = 1'b1
    } mode_t;

    // Input event, last field in the lowest bits
    typedef struct packed {
        logic        downstream_ready;
        logic [15:0] value;
        logic [31:0] row_index;
        logic [15:0] chunk;
        logic [15:0] descriptor;
        logic [5:0]  bank_group;
        logic [7:0]  valid_lanes;
        logic [3:0]  lane;
    } in_item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [15:0] value;
        logic [31:0] row_index;
        logic        half;
        logic [15:0] chunk;
        logic [15:0] descriptor;
        logic [5:0]  bank_group;
        logic [3:0]  lane;
    } out_item_t;

    // One staged entry as held in the entry memory
    typedef struct packed {
        logic [15:0] value;
        logic [31:0] row_index;
        logic [3:0]  lane;
    } entry_t;

    localparam int IN_ITEM_W   = $bits(in_item_t);
    localparam int OUT_ITEM_W  = $bits(out_item_t);
    localparam int ENTRY_W     = $bits(entry_t);
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 96;

endpackage

// ----- design/lbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lane_batch_stager_unit.sv -----
// Lane batch stager: stages lane events into a batch memory, flushes batches as runs.
// Every item but a good flush puts its one result in the output register in the cycle
//   after its transfer; one such item can transfer every cycle while the output is free.
// A good flush of n staged entries streams n entry results out of the entry memory, one
//   read per cycle while the output takes them; the input is held until the run ends.
// Reset (rst_n, async) clears mode, count, identity and output state, not the entry memory.
module lane_batch_stager_unit
    import lbs_pkg::*;
#(
    parameter int BATCH_LANES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: staging mode (0 serial forward, 1 batch staging)
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: in_lane, in_valid_lanes, in_bank_group, in_descriptor, in_chunk,
    //        in_row_index, in_value, downstream_ready, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation
    input  logic                   s_axis_tuser,
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: out_lane, out_bank_group, out_descriptor, out_chunk, out_half,
    //        out_row_index, out_value, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [3:0]             m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int CNT_W = $clog2(BATCH_LANES + 1);
    localparam int IDX_W = $clog2(BATCH_LANES);
    localparam logic [8:0] LANES_9 = 9'(BATCH_LANES);
    localparam logic [7:0] LANES_8 = 8'(BATCH_LANES);

    // Batch state
    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full_reg, full_next;
    logic [5:0]       bg_reg, bg_next;
    logic [15:0]      desc_reg, desc_next;
    logic [15:0]      chunk_reg, chunk_next;
    logic             half_reg, half_next;

    // Flush run state
    logic             run_active_reg, run_active_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    in_item_t         in_item;
    op_t              in_op;
    logic             in_fire;
    logic             half;
    logic [7:0]       expected;
    logic             exp_bad;
    logic [8:0]       lane_want;
    logic             lane_bad;
    logic             id_bad;
    logic [CNT_W-1:0] count_inc;
    logic             full_hit;

    status_t          res_status;
    logic             res_echo;
    logic             stage_wr;
    logic             flush_go;
    out_item_t        single_item;
    out_item_t        run_item;

    logic             issue;
    logic             rd_move;
    logic             rd_last;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rd_word;

    assign in_item = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    assign in_op   = op_t'(s_axis_tuser);

    // Take input when no run owns the output and the output register frees up
    assign s_axis_tready = !run_active_reg && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Lane checks against the batch being staged
    always_comb
    begin
        half = (9'(in_item.lane) >= LANES_9);
        if (half)
        begin
            expected = in_item.valid_lanes - LANES_8;
        end
        else
        begin
            expected = (in_item.valid_lanes < LANES_8) ? in_item.valid_lanes : LANES_8;
        end
        exp_bad   = (expected == 8'd0) || (9'(expected) > LANES_9);
        lane_want = (half ? LANES_9 : 9'd0) + 9'(count_reg);
        lane_bad  = (9'(in_item.lane) != lane_want);
        id_bad    = (count_reg != '0) &&
                    ((bg_reg != in_item.bank_group) || (desc_reg != in_item.descriptor) ||
                     (chunk_reg != in_item.chunk) || (half_reg != half));
        count_inc = count_reg + CNT_W'(1);
        full_hit  = (9'(count_inc) == 9'(expected));
    end

    // Decide what the current item does
    always_comb
    begin
        res_status = ST_NOTHING;
        res_echo   = 1'b0;
        stage_wr   = 1'b0;
        flush_go   = 1'b0;
        case (in_op)
            OP_ACCEPT:
            begin
                if (mode_reg == MODE_SERIAL)
                begin
                    if (in_item.downstream_ready)
                    begin
                        res_status = ST_FORWARD;
                        res_echo   = 1'b1;
                    end
                    else
                    begin
                        res_status = ST_NOT_READY;
                    end
                end
                else if (full_reg)
                begin
                    res_status = ST_NOT_READY;
                end
                else if (exp_bad || lane_bad)
                begin
                    res_status = ST_LANE_ERR;
                end
                else if (id_bad)
                begin
                    res_status = ST_ID_ERR;
                end
                else
                begin
                    stage_wr   = 1'b1;
                    res_echo   = 1'b1;
                    res_status = full_hit ? ST_FULL : ST_STAGED;
                end
            end
            OP_FLUSH:
            begin
                if (mode_reg == MODE_SERIAL || !full_reg)
                begin
                    res_status = ST_NOTHING;
                end
                else if (!in_item.downstream_ready)
                begin
                    res_status = ST_STALL;
                end
                else
                begin
                    flush_go = 1'b1;
                end
            end
            default:
            begin
                res_status = ST_NOTHING;
            end
        endcase
    end

    // Build the single result of the item
    always_comb
    begin
        single_item = '0;
        if (res_echo)
        begin
            single_item.lane       = in_item.lane;
            single_item.bank_group = in_item.bank_group;
            single_item.descriptor = in_item.descriptor;
            single_item.chunk      = in_item.chunk;
            single_item.half       = half;
            single_item.row_index  = in_item.row_index;
            single_item.value      = in_item.value;
        end
    end

    // Entry memory
    assign wr_entry.lane      = in_item.lane;
    assign wr_entry.row_index = in_item.row_index;
    assign wr_entry.value     = in_item.value;

    lbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BATCH_LANES)
    ) u_entries (
        .clk   (clk),
        .we    (in_fire && stage_wr),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (issue),
        .raddr (issue_idx_reg[IDX_W-1:0]),
        .rdata (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    // Run control: issue one read per cycle while read data moves on, advance read data into the output
    assign rd_move = rd_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue   = run_active_reg && (issue_idx_reg != count_reg) &&
                     (!rd_valid_reg || rd_move);
    assign rd_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        run_item            = '0;
        run_item.lane       = rd_entry.lane;
        run_item.bank_group = bg_reg;
        run_item.descriptor = desc_reg;
        run_item.chunk      = chunk_reg;
        run_item.half       = half_reg;
        run_item.row_index  = rd_entry.row_index;
        run_item.value      = rd_entry.value;
    end

    // Next state of batch and run
    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        full_next       = full_reg;
        bg_next         = bg_reg;
        desc_next       = desc_reg;
        chunk_next      = chunk_reg;
        half_next       = half_reg;
        run_active_next = run_active_reg;
        issue_idx_next  = issue_idx_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;

        if (cfg_wr_en)
        begin
            mode_next = mode_t'(cfg_wr_data);
        end

        // stage an accepted event
        if (in_fire && stage_wr)
        begin
            count_next = count_inc;
            full_next  = full_hit;
            if (count_reg == '0)
            begin
                bg_next    = in_item.bank_group;
                desc_next  = in_item.descriptor;
                chunk_next = in_item.chunk;
                half_next  = half;
            end
        end

        // start a run on a good flush
        if (in_fire && flush_go)
        begin
            run_active_next = 1'b1;
            issue_idx_next  = '0;
        end

        if (issue)
        begin
            issue_idx_next = issue_idx_reg + CNT_W'(1);
            rd_valid_next  = 1'b1;
            rd_idx_next    = issue_idx_reg[IDX_W-1:0];
        end
        else if (rd_move)
        begin
            rd_valid_next = 1'b0;
        end

        // drop the batch once its final entry is handed on
        if (rd_move && rd_last)
        begin
            run_active_next = 1'b0;
            count_next      = '0;
            full_next       = 1'b0;
            bg_next         = '0;
            desc_next       = '0;
            chunk_next      = '0;
            half_next       = 1'b0;
        end
    end

    // Next output register contents
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (rd_move)
        begin
            out_valid_next  = 1'b1;
            out_item_next   = run_item;
            out_status_next = ST_ENTRY;
            out_last_next   = rd_last;
        end
        else if (in_fire && !flush_go)
        begin
            out_valid_next  = 1'b1;
            out_item_next   = single_item;
            out_status_next = res_status;
            out_last_next   = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SERIAL;
            count_reg      <= '0;
            full_reg       <= 1'b0;
            bg_reg         <= '0;
            desc_reg       <= '0;
            chunk_reg      <= '0;
            half_reg       <= 1'b0;
            run_active_reg <= 1'b0;
            issue_idx_reg  <= '0;
            rd_valid_reg   <= 1'b0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            full_reg       <= full_next;
            bg_reg         <= bg_next;
            desc_reg       <= desc_next;
            chunk_reg      <= chunk_next;
            half_reg       <= half_next;
            run_active_reg <= run_active_next;
            issue_idx_reg  <= issue_idx_next;
            rd_valid_reg   <= rd_valid_next;
            rd_idx_reg     <= rd_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_item_reg   <= out_item_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_item_reg);
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- test/lane_batch_stager_unit_test.sv -----
// Self-checking testbench for the lane batch stager: directed table, then random batch and serial traffic.
module lane_batch_stager_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lbs_pkg::*;

    localparam int LANES       = 8;
    localparam int LONG_HOLD   = 80;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 12;

    // One result as it should leave the master side
    typedef struct packed {
        status_t   status;
        out_item_t data;
        logic      last;
    } stager_out_t;

    // One row of the directed table; typed rows carry their status by hand
    typedef struct packed {
        mode_t    mode;
        op_t      op;
        in_item_t ev;
        logic     typed;
        status_t  want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [3:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    // Predictor state: mode register and the batch being staged
    mode_t       stage_mode = MODE_SERIAL;
    entry_t      held_entries [LANES];
    int          held_count = 0;
    logic        held_full = 1'b0;
    logic [5:0]  held_bg = '0;
    logic [15:0] held_desc = '0;
    logic [15:0] held_chunk = '0;
    logic        held_half = 1'b0;

    stager_out_t outputs_due [$];
    plan_row_t   directed_plan [$];
    int          fault_count = 0;
    int          results_checked = 0;
    int          items_sent = 0;
    int          batches_flushed = 0;
    int          quiet_cycles = 0;
    bit          hold_asked = 1'b0;
    bit          sender_calm = 1'b0;

    lane_batch_stager_unit #(
        .BATCH_LANES(LANES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Build an event from plain numbers
    function automatic in_item_t event_of(int lane, int valid, int bg, int desc, int chunk,
                                          int unsigned row, int value, bit ready);
        in_item_t e;
        e.lane             = 4'(lane);
        e.valid_lanes      = 8'(valid);
        e.bank_group       = 6'(bg);
        e.descriptor       = 16'(desc);
        e.chunk            = 16'(chunk);
        e.row_index        = 32'(row);
        e.value            = 16'(value);
        e.downstream_ready = ready;
        return e;
    endfunction

    // Draw an event with every bit random
    function automatic in_item_t any_event();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[IN_ITEM_W-1:0];
    endfunction

    // Append one expected result to the scoreboard
    task automatic queue_result(stager_out_t r);
        outputs_due = {outputs_due, r};
    endtask

    // Append one row to the directed table
    task automatic add_row(mode_t m, op_t op, in_item_t ev, logic typed, status_t want);
        plan_row_t p;
        p = '{m, op, ev, typed, want};
        directed_plan = {directed_plan, p};
    endtask

    // Stage, forward or flush one item and queue the results it must cause
    task automatic stage_or_flush(op_t op, in_item_t ev);
        stager_out_t r;
        logic        half;
        logic        echo;
        int          want;
        half = ev.lane >= 4'(LANES);
        echo = 1'b0;
        r = '{status: ST_NOTHING, data: '0, last: 1'b1};
        if (op == OP_ACCEPT) begin
            if (stage_mode == MODE_SERIAL) begin
                r.status = ev.downstream_ready ? ST_FORWARD : ST_NOT_READY;
                echo = ev.downstream_ready;
            end else if (held_full) begin
                r.status = ST_NOT_READY;
            end else begin
                if (half)
                    want = (int'(ev.valid_lanes) - LANES) & 255;
                else
                    want = int'(ev.valid_lanes) < LANES ? int'(ev.valid_lanes) : LANES;
                if (want == 0 || want > LANES ||
                    int'(ev.lane) != int'(half) * LANES + held_count) begin
                    r.status = ST_LANE_ERR;
                end else if (held_count != 0 &&
                             (held_bg != ev.bank_group || held_desc != ev.descriptor ||
                              held_chunk != ev.chunk || held_half != half)) begin
                    r.status = ST_ID_ERR;
                end else begin
                    // capture the batch identity on its first lane
                    if (held_count == 0) begin
                        held_bg    = ev.bank_group;
                        held_desc  = ev.descriptor;
                        held_chunk = ev.chunk;
                        held_half  = half;
                    end
                    held_entries[held_count] = '{value: ev.value, row_index: ev.row_index,
                                                 lane: ev.lane};
                    held_count++;
                    held_full = held_count == want;
                    r.status  = held_full ? ST_FULL : ST_STAGED;
                    echo      = 1'b1;
                end
            end
            if (echo) begin
                r.data.lane       = ev.lane;
                r.data.bank_group = ev.bank_group;
                r.data.descriptor = ev.descriptor;
                r.data.chunk      = ev.chunk;
                r.data.half       = half;
                r.data.row_index  = ev.row_index;
                r.data.value      = ev.value;
            end
            queue_result(r);
        end else if (stage_mode == MODE_SERIAL || !held_full) begin
            queue_result(r);
        end else if (!ev.downstream_ready) begin
            r.status = ST_STALL;
            queue_result(r);
        end else begin
            // emit the batch in staging order, then empty the stager
            for (int k = 0; k < held_count; k++) begin
                r.status          = ST_ENTRY;
                r.data.lane       = held_entries[k].lane;
                r.data.bank_group = held_bg;
                r.data.descriptor = held_desc;
                r.data.chunk      = held_chunk;
                r.data.half       = held_half;
                r.data.row_index  = held_entries[k].row_index;
                r.data.value      = held_entries[k].value;
                r.last            = k == held_count - 1;
                queue_result(r);
            end
            batches_flushed++;
            held_count = 0;
            held_full  = 1'b0;
            held_bg    = '0;
            held_desc  = '0;
            held_chunk = '0;
            held_half  = 1'b0;
        end
    endtask

    // Offer one item after a random gap and hold it until the transfer
    task automatic offer(op_t op, in_item_t ev);
        int gap;
        if ($urandom_range(0, 15) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(ev);
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic run(op_t op, in_item_t ev);
        stage_or_flush(op, ev);
        offer(op, ev);
    endtask

    // Drain all results, then write the mode register
    task automatic switch_mode(mode_t m);
        s_axis_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        stage_mode = m;
    endtask

    // Mostly well-formed batches with random content, some noise and broken lanes or identities
    task automatic batch_traffic(int budget);
        in_item_t ev;
        int       pick;
        int       seq_half;
        int       seq_size;
        seq_half = 0;
        seq_size = 0;
        while (budget > 0) begin
            pick = $urandom_range(0, 9);
            ev   = any_event();
            if (pick == 0) begin
                run(op_t'($urandom_range(0, 1)), ev);
            end else if (held_full) begin
                // stall, knock on a full batch, or drain it
                pick = $urandom_range(0, 3);
                ev.downstream_ready = pick != 0;
                run(pick == 1 ? OP_ACCEPT : OP_FLUSH, ev);
            end else begin
                if (held_count == 0) begin
                    seq_half = $urandom_range(0, 1);
                    seq_size = $urandom_range(1, LANES);
                end else begin
                    // resume whatever batch is open
                    seq_half = int'(held_half);
                    if (seq_size <= held_count)
                        seq_size = $urandom_range(held_count + 1, LANES);
                    ev.bank_group = held_bg;
                    ev.descriptor = held_desc;
                    ev.chunk      = held_chunk;
                end
                ev.lane = 4'(seq_half * LANES + held_count);
                if (seq_half != 0)
                    ev.valid_lanes = 8'(seq_size + LANES);
                else if (seq_size == LANES)
                    ev.valid_lanes = 8'($urandom_range(LANES, 255));
                else
                    ev.valid_lanes = 8'(seq_size);
                // break the sequence now and then
                pick = $urandom_range(0, 11);
                if (pick == 0)
                    ev.bank_group = ev.bank_group ^ 6'd1;
                else if (pick == 1)
                    ev.lane = ev.lane + 4'd1;
                run(OP_ACCEPT, ev);
            end
            budget--;
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int stall;
        bit calm;
        m_axis_tready = 1'b0;
        calm = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_asked) begin
                hold_asked = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge clk) begin
        stager_out_t due;
        out_item_t   got;
        logic        bad;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_ITEM_W-1:0];
            if (outputs_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d data %h last %b",
                             m_axis_tuser, got, m_axis_tlast);
            end else begin
                due = outputs_due.pop_front();
                results_checked++;
                bad = m_axis_tuser !== due.status ||
                      got.lane !== due.data.lane ||
                      got.bank_group !== due.data.bank_group ||
                      got.descriptor !== due.data.descriptor ||
                      got.chunk !== due.data.chunk ||
                      got.half !== due.data.half ||
                      got.row_index !== due.data.row_index ||
                      got.value !== due.data.value ||
                      m_axis_tlast !== due.last ||
                      m_axis_tdata[OUT_TDATA_W-1:OUT_ITEM_W] !== '0;
                if (bad) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch: want status %0d data %h last %b,",
                                  " got status %0d data %h last %b"},
                                 due.status, due.data, due.last, m_axis_tuser,
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, outputs_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain, verdict
    initial begin
        plan_row_t row;
        in_item_t  ev;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;

        // serial mode after reset
        add_row(MODE_SERIAL, OP_ACCEPT, event_of(3, 4, 1, 1, 1, 1, 1, 0),
                1'b1, ST_NOT_READY);
        add_row(MODE_SERIAL, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b1, ST_NOTHING);
        add_row(MODE_SERIAL, OP_ACCEPT,
                event_of(15, 255, 63, 'hFFFF, 'hFFFF, 'hFFFF_FFFF, 'hFFFF, 1),
                1'b0, ST_STAGED);
        add_row(MODE_SERIAL, OP_ACCEPT, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b0, ST_STAGED);
        // batch mode: empty flush, bad sizes, bad lane order
        add_row(MODE_BATCH, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b1, ST_NOTHING);
        add_row(MODE_BATCH, OP_ACCEPT, event_of(0, 0, 5, 'h1111, 'h2222, 0, 0, 1),
                1'b1, ST_LANE_ERR);
        add_row(MODE_BATCH, OP_ACCEPT, event_of(8, 8, 5, 'h1111, 'h2222, 0, 0, 1),
                1'b1, ST_LANE_ERR);
        add_row(MODE_BATCH, OP_ACCEPT, event_of(8, 255, 5, 'h1111, 'h2222, 0, 0, 1),
                1'b1, ST_LANE_ERR);
        add_row(MODE_BATCH, OP_ACCEPT, event_of(1, 3, 5, 'h1111, 'h2222, 0, 0, 1),
                1'b1, ST_LANE_ERR);
        // three-lane batch with identity faults along the way
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(0, 3, 5, 'h1111, 'h2222, 'h10, 'h3C00, 1),
                1'b0, ST_STAGED);
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(9, 10, 5, 'h1111, 'h2222, 'h20, 'h1, 1),
                1'b1, ST_ID_ERR);
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(1, 3, 6, 'h1111, 'h2222, 'h30, 'h2, 1),
                1'b1, ST_ID_ERR);
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(1, 3, 5, 'h1111, 'h2222, 'h11, 'hBC00, 0),
                1'b0, ST_STAGED);
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(2, 3, 5, 'h1111, 'h2222, 'h12, 'h7BFF, 1),
                1'b0, ST_STAGED);
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(3, 3, 5, 'h1111, 'h2222, 'h13, 'h3, 1),
                1'b1, ST_NOT_READY);
        add_row(MODE_BATCH, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, ST_STALL);
        // mode change keeps the full batch
        add_row(MODE_SERIAL, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b1, ST_NOTHING);
        add_row(MODE_SERIAL, OP_ACCEPT,
                event_of(7, 2, 33, 'hABCD, 'h1234, 'hDEAD_BEEF, 'h8001, 1),
                1'b0, ST_STAGED);
        add_row(MODE_BATCH, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b0, ST_STAGED);
        // single-lane batch in the upper half
        add_row(MODE_BATCH, OP_ACCEPT,
                event_of(8, 9, 40, 'h0F0F, 'hF0F0, 'h8000_0000, 'h7C00, 1),
                1'b0, ST_STAGED);
        add_row(MODE_BATCH, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 0),
                1'b1, ST_STALL);
        add_row(MODE_BATCH, OP_FLUSH, event_of(0, 0, 0, 0, 0, 0, 0, 1),
                1'b0, ST_STAGED);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < directed_plan.size(); i++) begin
            row = directed_plan[i];
            if (row.mode != stage_mode)
                switch_mode(row.mode);
            if (row.typed)
                queue_result('{status: row.want, data: '0, last: 1'b1});
            else
                stage_or_flush(row.op, row.ev);
            offer(row.op, row.ev);
        end

        // random phases, alternating batch and serial mode
        for (int phase = 0; phase < 5; phase++) begin
            if (phase % 2 == 0) begin
                switch_mode(MODE_BATCH);
                if (phase == 0)
                    hold_asked = 1'b1;
                batch_traffic(25);
            end else begin
                switch_mode(MODE_SERIAL);
                for (int i = 0; i < 12; i++) begin
                    ev = any_event();
                    if ($urandom_range(0, 3) != 0)
                        ev.downstream_ready = 1'b1;
                    run($urandom_range(0, 5) == 0 ? OP_FLUSH : OP_ACCEPT, ev);
                end
            end
        end

        // drain and let the block settle
        s_axis_tvalid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        fault_count += outputs_due.size();

        $display("covered %0d input transfers in serial and batch modes, %0d results checked",
                 items_sent, results_checked);
        $display("%0d batches flushed, %0d faults", batches_flushed, fault_count);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
